[rtl/wmm_pkg.sv]
// Shared types and constants for the window mean and maximum tracker.
// Depends on nothing; used by the serial divider and the top level.
package wmm_pkg;

   localparam int FieldBits = 16;
   localparam int FillBits  = 7;

   typedef logic [FieldBits-1:0] field_type;
   typedef logic [FillBits-1:0]  fill_type;

   localparam logic CmdPush  = 1'b0;
   localparam logic CmdClear = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/window_mean_max_tracker.sv]
// Sliding-window mean and maximum of two sample channels over the last WINDOW
// push requests. A push request updates the sums, then scans the ring memory
// read port for the maximum while the serial divider forms both averages in
// turn; a clear request empties the window and goes straight to the response.
// One request is worked at a time; the finished response waits in an output
// register while the next request is accepted. Depends on wmm_pkg, wmm_ring
// and wmm_div.
module window_mean_max_tracker #(
   parameter int WINDOW      = 100,
   parameter int SAMPLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  wmm_pkg::field_type req_cpu_sample,
   input  wmm_pkg::field_type req_mem_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wmm_pkg::field_type rsp_cpu_average,
   output wmm_pkg::field_type rsp_cpu_peak,
   output wmm_pkg::field_type rsp_mem_average,
   output wmm_pkg::field_type rsp_mem_peak,
   output wmm_pkg::fill_type  rsp_fill_count
);
   import wmm_pkg::*;

   localparam int ADDR_W  = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = SAMPLE_BITS + CNT_W;
   localparam int STATE_W = 3;

   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] ST_UPDATE = 3'd1;
   localparam logic [STATE_W-1:0] ST_START  = 3'd2;
   localparam logic [STATE_W-1:0] ST_SCAN   = 3'd3;
   localparam logic [STATE_W-1:0] ST_DONE   = 3'd4;

   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

   logic [STATE_W-1:0]     state_ff, state_in;
   logic [ADDR_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       held_ff, held_in;
   logic [SUM_W-1:0]       cpu_sum_ff, cpu_sum_in;
   logic [SUM_W-1:0]       mem_sum_ff, mem_sum_in;
   logic [SAMPLE_BITS-1:0] new_cpu_ff, new_cpu_in;
   logic [SAMPLE_BITS-1:0] new_mem_ff, new_mem_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [SAMPLE_BITS-1:0] cpu_peak_ff, cpu_peak_in;
   logic [SAMPLE_BITS-1:0] mem_peak_ff, mem_peak_in;
   logic [SUM_W-1:0]       cpu_avg_ff, cpu_avg_in;
   logic [SUM_W-1:0]       mem_avg_ff, mem_avg_in;
   logic                   div_sel_ff, div_sel_in;
   logic                   avg_ok_ff, avg_ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   field_type              rsp_cpu_avg_ff, rsp_cpu_avg_in;
   field_type              rsp_cpu_peak_ff, rsp_cpu_peak_in;
   field_type              rsp_mem_avg_ff, rsp_mem_avg_in;
   field_type              rsp_mem_peak_ff, rsp_mem_peak_in;
   fill_type               rsp_fill_ff, rsp_fill_in;

   logic                   accept;
   logic                   full;
   logic                   rsp_load;
   logic [ADDR_W-1:0]      rd_addr;
   logic [SAMPLE_BITS-1:0] rd_cpu;
   logic [SAMPLE_BITS-1:0] rd_mem;
   logic                   wr_en;
   logic                   div_start;
   logic [SUM_W-1:0]       div_dividend;
   logic [SUM_W-1:0]       div_quotient;
   div_status_type         div_status;

   logic [SAMPLE_BITS+FieldBits-1:0] cpu_in_wide;
   logic [SAMPLE_BITS+FieldBits-1:0] mem_in_wide;
   logic [SUM_W+FieldBits-1:0]       cpu_avg_wide;
   logic [SUM_W+FieldBits-1:0]       mem_avg_wide;
   logic [SAMPLE_BITS+FieldBits-1:0] cpu_peak_wide;
   logic [SAMPLE_BITS+FieldBits-1:0] mem_peak_wide;
   logic [CNT_W+FillBits-1:0]        held_wide;

   assign accept        = req_valid && !req_stall;
   assign req_stall     = state_ff != ST_IDLE;
   assign full          = held_ff == FULL_CNT;
   assign wr_en         = state_ff == ST_UPDATE;
   assign rd_addr       = (state_ff == ST_SCAN) ? scan_ff[ADDR_W-1:0] : slot_ff;
   assign div_dividend  = (state_ff == ST_START) ? cpu_sum_ff : mem_sum_ff;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign cpu_in_wide   = {{SAMPLE_BITS{1'b0}}, req_cpu_sample};
   assign mem_in_wide   = {{SAMPLE_BITS{1'b0}}, req_mem_sample};
   assign cpu_avg_wide  = {{FieldBits{1'b0}}, cpu_avg_ff};
   assign mem_avg_wide  = {{FieldBits{1'b0}}, mem_avg_ff};
   assign cpu_peak_wide = {{FieldBits{1'b0}}, cpu_peak_ff};
   assign mem_peak_wide = {{FieldBits{1'b0}}, mem_peak_ff};
   assign held_wide     = {{FillBits{1'b0}}, held_ff};

   wmm_ring #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_cpu  (new_cpu_ff),
      .wr_mem  (new_mem_ff),
      .rd_addr (rd_addr),
      .rd_cpu  (rd_cpu),
      .rd_mem  (rd_mem)
   );

   wmm_div #(
      .NUM_BITS (SUM_W),
      .DEN_BITS (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (held_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in        = state_ff;
      slot_in         = slot_ff;
      held_in         = held_ff;
      cpu_sum_in      = cpu_sum_ff;
      mem_sum_in      = mem_sum_ff;
      new_cpu_in      = new_cpu_ff;
      new_mem_in      = new_mem_ff;
      scan_in         = scan_ff;
      pend_in         = 1'b0;
      cpu_peak_in     = cpu_peak_ff;
      mem_peak_in     = mem_peak_ff;
      cpu_avg_in      = cpu_avg_ff;
      mem_avg_in      = mem_avg_ff;
      div_sel_in      = div_sel_ff;
      avg_ok_in       = avg_ok_ff;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_cpu_avg_in  = rsp_cpu_avg_ff;
      rsp_cpu_peak_in = rsp_cpu_peak_ff;
      rsp_mem_avg_in  = rsp_mem_avg_ff;
      rsp_mem_peak_in = rsp_mem_peak_ff;
      rsp_fill_in     = rsp_fill_ff;

      // The two averages are formed one after the other while the scan runs.
      if (div_status.done) begin
         if (!div_sel_ff) begin
            cpu_avg_in = div_quotient;
            div_sel_in = 1'b1;
            div_start  = 1'b1;
         end else begin
            mem_avg_in = div_quotient;
            avg_ok_in  = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_cpu_in = cpu_in_wide[SAMPLE_BITS-1:0];
               new_mem_in = mem_in_wide[SAMPLE_BITS-1:0];
               if (req_cmd == CmdClear) begin
                  slot_in    = '0;
                  held_in    = '0;
                  cpu_sum_in = '0;
                  mem_sum_in = '0;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (full) begin
               cpu_sum_in = cpu_sum_ff - {{CNT_W{1'b0}}, rd_cpu}
                            + {{CNT_W{1'b0}}, new_cpu_ff};
               mem_sum_in = mem_sum_ff - {{CNT_W{1'b0}}, rd_mem}
                            + {{CNT_W{1'b0}}, new_mem_ff};
            end else begin
               cpu_sum_in = cpu_sum_ff + {{CNT_W{1'b0}}, new_cpu_ff};
               mem_sum_in = mem_sum_ff + {{CNT_W{1'b0}}, new_mem_ff};
               held_in    = held_ff + 1'b1;
            end
            slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            div_start   = 1'b1;
            div_sel_in  = 1'b0;
            avg_ok_in   = 1'b0;
            scan_in     = '0;
            cpu_peak_in = '0;
            mem_peak_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff != held_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (rd_cpu > cpu_peak_ff) begin
                  cpu_peak_in = rd_cpu;
               end
               if (rd_mem > mem_peak_ff) begin
                  mem_peak_in = rd_mem;
               end
            end
            if ((scan_ff == held_ff) && !pend_ff && avg_ok_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_fill_in  = held_wide[FillBits-1:0];
               if (held_ff == '0) begin
                  rsp_cpu_avg_in  = '0;
                  rsp_cpu_peak_in = '0;
                  rsp_mem_avg_in  = '0;
                  rsp_mem_peak_in = '0;
               end else begin
                  rsp_cpu_avg_in  = cpu_avg_wide[FieldBits-1:0];
                  rsp_cpu_peak_in = cpu_peak_wide[FieldBits-1:0];
                  rsp_mem_avg_in  = mem_avg_wide[FieldBits-1:0];
                  rsp_mem_peak_in = mem_peak_wide[FieldBits-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         held_ff      <= '0;
         cpu_sum_ff   <= '0;
         mem_sum_ff   <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         div_sel_ff   <= 1'b0;
         avg_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         held_ff      <= held_in;
         cpu_sum_ff   <= cpu_sum_in;
         mem_sum_ff   <= mem_sum_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         div_sel_ff   <= div_sel_in;
         avg_ok_ff    <= avg_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_cpu_ff      <= new_cpu_in;
      new_mem_ff      <= new_mem_in;
      cpu_peak_ff     <= cpu_peak_in;
      mem_peak_ff     <= mem_peak_in;
      cpu_avg_ff      <= cpu_avg_in;
      mem_avg_ff      <= mem_avg_in;
      rsp_cpu_avg_ff  <= rsp_cpu_avg_in;
      rsp_cpu_peak_ff <= rsp_cpu_peak_in;
      rsp_mem_avg_ff  <= rsp_mem_avg_in;
      rsp_mem_peak_ff <= rsp_mem_peak_in;
      rsp_fill_ff     <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cpu_average = rsp_cpu_avg_ff;
   assign rsp_cpu_peak    = rsp_cpu_peak_ff;
   assign rsp_mem_average = rsp_mem_avg_ff;
   assign rsp_mem_peak    = rsp_mem_peak_ff;
   assign rsp_fill_count  = rsp_fill_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL_CNT)
      else $error("Held count exceeds the window size.");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("Divider started while still busy.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CmdClear)) |=> (held_ff == '0) && (slot_ff == '0))
      else $error("Clear request did not empty the window.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("Response raised outside the done state.");

   a_avg_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (held_ff != '0)) |-> avg_ok_ff)
      else $error("Response reached before both averages were ready.");

endmodule

[rtl/wmm_ring.sv]
// Sample ring storage for both channels: one write port and one registered
// read port, shared address for the two channels. No package dependency.
module wmm_ring #(
   parameter int WINDOW      = 100,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(WINDOW)-1:0]  wr_addr,
   input  logic [SAMPLE_BITS-1:0]     wr_cpu,
   input  logic [SAMPLE_BITS-1:0]     wr_mem,
   input  logic [$clog2(WINDOW)-1:0]  rd_addr,
   output logic [SAMPLE_BITS-1:0]     rd_cpu,
   output logic [SAMPLE_BITS-1:0]     rd_mem
);

   logic [SAMPLE_BITS-1:0] cpu_ram [WINDOW];
   logic [SAMPLE_BITS-1:0] mem_ram [WINDOW];
   logic [SAMPLE_BITS-1:0] rd_cpu_ff;
   logic [SAMPLE_BITS-1:0] rd_mem_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cpu_ram[wr_addr] <= wr_cpu;
         mem_ram[wr_addr] <= wr_mem;
      end
      rd_cpu_ff <= cpu_ram[rd_addr];
      rd_mem_ff <= mem_ram[rd_addr];
   end

   assign rd_cpu = rd_cpu_ff;
   assign rd_mem = rd_mem_ff;

endmodule

[rtl/wmm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on wmm_pkg for the status struct.
module wmm_div #(
   parameter int NUM_BITS = 23,
   parameter int DEN_BITS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_BITS-1:0]    dividend,
   input  logic [DEN_BITS-1:0]    divisor,
   output logic [NUM_BITS-1:0]    quotient,
   output wmm_pkg::div_status_type status
);
   import wmm_pkg::*;

   localparam int STEP_W = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
